// ===== src/ipm_pkg.sv =====
`default_nettype none
package ipm_pkg;

  // Field and register widths
  localparam int unsigned PIX_W  = 12;
  localparam int unsigned CFG_W  = 64;
  localparam int unsigned OFF_W  = 16;
  localparam int unsigned COEF_W = 21;
  localparam int unsigned GND_W  = 24;
  localparam int unsigned VIEW_W = 16;

  // Bearing arithmetic: |b| stays below 2^34, so a magnitude fits in 34 bits
  localparam int unsigned PROD_W = COEF_W + PIX_W + 1;
  localparam int unsigned BEAR_W = PROD_W + 1;
  localparam int unsigned MAG_W  = BEAR_W - 1;
  localparam int unsigned HALF_W = MAG_W / 2;
  localparam int unsigned SQ_W   = 2 * MAG_W;
  localparam int unsigned CMP_W  = SQ_W + 14;

  // Ground quotient: a hit keeps |b.x / b.z| below 100, so |q| < 100 * 2^15 < 2^22
  localparam int unsigned GNUM_W = MAG_W + OFF_W;
  localparam int unsigned GQ_W   = 22;

  // Signed difference range minus ground coordinate
  localparam int unsigned DIFF_W = 26;

  typedef enum logic [2:0] {
    CFG_ROW_X  = 3'd0,
    CFG_ROW_Y  = 3'd1,
    CFG_ROW_Z  = 3'd2,
    CFG_OFF_X  = 3'd3,
    CFG_OFF_Y  = 3'd4,
    CFG_HEIGHT = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] row_x;
    logic [CFG_W-1:0] row_y;
    logic [CFG_W-1:0] row_z;
  } ipm_mat_t;

  function automatic logic signed [COEF_W-1:0] coef_f(input logic [CFG_W-1:0] row,
                                                      input int unsigned k);
    logic [CFG_W-1:0] sh;
    sh = row >> (COEF_W * k);
    return $signed(sh[COEF_W-1:0]);
  endfunction

endpackage
`default_nettype wire

// ===== src/ipm_if.sv =====
`default_nettype none
interface ipm_pix_if import ipm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;

  modport source(output valid, output pixel_x, output pixel_y, input ready);
  modport sink(input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface ipm_res_if import ipm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     hit_valid;
  logic signed [GND_W-1:0]  ground_x;
  logic signed [GND_W-1:0]  ground_y;
  logic signed [VIEW_W-1:0] view_col;
  logic signed [VIEW_W-1:0] view_row;

  modport source(output valid, output hit_valid, output ground_x, output ground_y,
                 output view_col, output view_row, input ready);
  modport sink(input valid, input hit_valid, input ground_x, input ground_y,
               input view_col, input view_row, output ready);
endinterface
`default_nettype wire

// ===== src/ground_plane_pixel_projection.sv =====
// Projects one camera pixel per clock onto the ground plane and into a square
// bird's-eye view. A new pixel transaction is taken every cycle; the whole
// pipeline advances together and holds while a finished result waits at the
// output register. An accepted pixel passes 2 stages for the bearing, 4 for
// the steepness test, 22 for the restoring divider pipelines of the ground
// intersection (one per quotient bit), 1 for the camera offset, 3 for the
// bird's-eye mapping by reciprocal multiplication and 1 for the output
// register. The user must write configuration registers only while no
// transaction is in flight; the block itself does not enforce this.
`default_nettype none
module ground_plane_pixel_projection import ipm_pkg::*; #(
  parameter int unsigned VIEW_SIZE     = 800,
  parameter int unsigned VIEW_RANGE_MM = 30000
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ipm_pix_if.sink          pix_i,
  ipm_res_if.source        res_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  ipm_mat_t                 mat_q;
  logic signed [OFF_W-1:0]  tx_q;
  logic signed [OFF_W-1:0]  ty_q;
  logic signed [OFF_W-1:0]  tz_q;
  logic                     en;
  logic                     b_vld;
  logic signed [BEAR_W-1:0] bx;
  logic signed [BEAR_W-1:0] by;
  logic signed [BEAR_W-1:0] bz;
  logic                     h_vld;
  logic                     h_hit;
  logic                     h_neg_x;
  logic                     h_neg_y;
  logic [GNUM_W-1:0]        h_num_x;
  logic [GNUM_W-1:0]        h_num_y;
  logic [MAG_W-1:0]         h_den;
  logic                     dx_vld;
  logic                     dy_vld;
  logic [GQ_W-1:0]          qx;
  logic [GQ_W-1:0]          qy;
  logic [1:0]               dx_tag;
  logic [0:0]               dy_tag;
  logic signed [GND_W-1:0]  qxs;
  logic signed [GND_W-1:0]  qys;
  logic signed [GND_W-1:0]  gx_d;
  logic signed [GND_W-1:0]  gy_d;
  logic signed [GND_W-1:0]  gx_q;
  logic signed [GND_W-1:0]  gy_q;
  logic                     g_hit_q;
  logic                     g_vld_q;
  logic                     v_vld;
  logic                     v_hit;
  logic signed [GND_W-1:0]  v_gx;
  logic signed [GND_W-1:0]  v_gy;
  logic signed [VIEW_W-1:0] v_col;
  logic signed [VIEW_W-1:0] v_row;
  logic                     out_vld_q;
  logic                     out_hit_q;
  logic signed [GND_W-1:0]  out_gx_q;
  logic signed [GND_W-1:0]  out_gy_q;
  logic signed [VIEW_W-1:0] out_col_q;
  logic signed [VIEW_W-1:0] out_row_q;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= '0;
      tx_q  <= '0;
      ty_q  <= '0;
      tz_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ROW_X:  mat_q.row_x <= cfg_data_i;
        CFG_ROW_Y:  mat_q.row_y <= cfg_data_i;
        CFG_ROW_Z:  mat_q.row_z <= cfg_data_i;
        CFG_OFF_X:  tx_q <= $signed(cfg_data_i[OFF_W-1:0]);
        CFG_OFF_Y:  ty_q <= $signed(cfg_data_i[OFF_W-1:0]);
        CFG_HEIGHT: tz_q <= $signed(cfg_data_i[OFF_W-1:0]);
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline unless a held result blocks the output
  assign en          = !out_vld_q || res_o.ready;
  assign pix_i.ready = en;

  ipm_bearing u_ray (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (pix_i.valid),
    .pixel_x_i (pix_i.pixel_x),
    .pixel_y_i (pix_i.pixel_y),
    .mat_i     (mat_q),
    .valid_o   (b_vld),
    .bx_o      (bx),
    .by_o      (by),
    .bz_o      (bz)
  );

  ipm_hit_test u_hit_test (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b_vld),
    .bx_i    (bx),
    .by_i    (by),
    .bz_i    (bz),
    .tz_i    (tz_q),
    .valid_o (h_vld),
    .hit_o   (h_hit),
    .neg_x_o (h_neg_x),
    .neg_y_o (h_neg_y),
    .num_x_o (h_num_x),
    .num_y_o (h_num_y),
    .den_o   (h_den)
  );

  ipm_div #(
    .NUM_W (GNUM_W),
    .DEN_W (MAG_W),
    .QUO_W (GQ_W),
    .TAG_W (2)
  ) u_div_gx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (h_vld),
    .num_i   (h_num_x),
    .den_i   (h_den),
    .tag_i   ({h_hit, h_neg_x}),
    .valid_o (dx_vld),
    .quo_o   (qx),
    .tag_o   (dx_tag)
  );

  ipm_div #(
    .NUM_W (GNUM_W),
    .DEN_W (MAG_W),
    .QUO_W (GQ_W),
    .TAG_W (1)
  ) u_div_gy (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (h_vld),
    .num_i   (h_num_y),
    .den_i   (h_den),
    .tag_i   (h_neg_y),
    .valid_o (dy_vld),
    .quo_o   (qy),
    .tag_o   (dy_tag)
  );

  // Add the camera offset; on a hit the sum stays well inside 24 bits
  always_comb begin
    qxs  = dx_tag[0] ? -GND_W'(qx) : GND_W'(qx);
    qys  = dy_tag[0] ? -GND_W'(qy) : GND_W'(qy);
    gx_d = dx_tag[1] ? GND_W'(tx_q) + qxs : '0;
    gy_d = dx_tag[1] ? GND_W'(ty_q) + qys : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gx_q    <= gx_d;
      gy_q    <= gy_d;
      g_hit_q <= dx_tag[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else if (en) begin
      g_vld_q <= dx_vld & dy_vld;
    end
  end

  ipm_view #(
    .VIEW_SIZE     (VIEW_SIZE),
    .VIEW_RANGE_MM (VIEW_RANGE_MM)
  ) u_view (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (g_vld_q),
    .hit_i   (g_hit_q),
    .gx_i    (gx_q),
    .gy_i    (gy_q),
    .valid_o (v_vld),
    .hit_o   (v_hit),
    .gx_o    (v_gx),
    .gy_o    (v_gy),
    .col_o   (v_col),
    .row_o   (v_row)
  );

  // Hold the result until the sink takes the transaction
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_hit_q <= v_hit;
      out_gx_q  <= v_gx;
      out_gy_q  <= v_gy;
      out_col_q <= v_col;
      out_row_q <= v_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= v_vld;
    end
  end

  assign res_o.valid     = out_vld_q;
  assign res_o.hit_valid = out_hit_q;
  assign res_o.ground_x  = out_gx_q;
  assign res_o.ground_y  = out_gy_q;
  assign res_o.view_col  = out_col_q;
  assign res_o.view_row  = out_row_q;

`ifndef ASSERT_OFF
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.hit_valid |->
      res_o.ground_x == 0 && res_o.ground_y == 0 &&
      res_o.view_col == 0 && res_o.view_row == 0)
    else $error("rejected pixel with nonzero result");

  a_ground_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.hit_valid |->
      res_o.ground_x >= -24'sd4227072 && res_o.ground_x <= 24'sd4227072 &&
      res_o.ground_y >= -24'sd4227072 && res_o.ground_y <= 24'sd4227072)
    else $error("ground point beyond reach of a steep ray");

  a_row_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.hit_valid && res_o.ground_x <= 0 |-> !res_o.view_row[VIEW_W-1])
    else $error("view row on wrong side of the center");
`endif

endmodule
`default_nettype wire

// ===== src/ipm_bearing.sv =====
`default_nettype none
module ipm_bearing import ipm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [PIX_W-1:0]         pixel_x_i,
  input  logic [PIX_W-1:0]         pixel_y_i,
  input  ipm_mat_t                 mat_i,
  output logic                     valid_o,
  output logic signed [BEAR_W-1:0] bx_o,
  output logic signed [BEAR_W-1:0] by_o,
  output logic signed [BEAR_W-1:0] bz_o
);

  logic [CFG_W-1:0]         rows [3];
  logic signed [PROD_W-1:0] px_d [3];
  logic signed [PROD_W-1:0] py_d [3];
  logic signed [PROD_W-1:0] px_q [3];
  logic signed [PROD_W-1:0] py_q [3];
  logic signed [PROD_W-1:0] c2_q [3];
  logic signed [BEAR_W-1:0] b_d  [3];
  logic signed [BEAR_W-1:0] b_q  [3];
  logic signed [PIX_W:0]    xs;
  logic signed [PIX_W:0]    ys;
  logic [1:0]               vld_q;

  assign rows[0] = mat_i.row_x;
  assign rows[1] = mat_i.row_y;
  assign rows[2] = mat_i.row_z;
  assign xs = $signed({1'b0, pixel_x_i});
  assign ys = $signed({1'b0, pixel_y_i});

  // Form the per-row products of the coefficients with the pixel
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      px_d[a] = PROD_W'(coef_f(rows[a], 0)) * PROD_W'(xs);
      py_d[a] = PROD_W'(coef_f(rows[a], 1)) * PROD_W'(ys);
    end
  end

  // Add the products and the constant column
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      b_d[a] = BEAR_W'(px_q[a]) + BEAR_W'(py_q[a]) + BEAR_W'(c2_q[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < 3; a++) begin
        px_q[a] <= px_d[a];
        py_q[a] <= py_d[a];
        c2_q[a] <= PROD_W'(coef_f(rows[a], 2));
        b_q[a]  <= b_d[a];
      end
    end
  end

  // Advance the valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  assign valid_o = vld_q[1];
  assign bx_o    = b_q[0];
  assign by_o    = b_q[1];
  assign bz_o    = b_q[2];

endmodule
`default_nettype wire

// ===== src/ipm_hit_test.sv =====
`default_nettype none
module ipm_hit_test import ipm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [BEAR_W-1:0] bx_i,
  input  logic signed [BEAR_W-1:0] by_i,
  input  logic signed [BEAR_W-1:0] bz_i,
  input  logic signed [OFF_W-1:0]  tz_i,
  output logic                     valid_o,
  output logic                     hit_o,
  output logic                     neg_x_o,
  output logic                     neg_y_o,
  output logic [GNUM_W-1:0]        num_x_o,
  output logic [GNUM_W-1:0]        num_y_o,
  output logic [MAG_W-1:0]         den_o
);

  typedef struct packed {
    logic [GNUM_W-1:0] num_x;
    logic [GNUM_W-1:0] num_y;
    logic [MAG_W-1:0]  den;
    logic              neg_x;
    logic              neg_y;
    logic              bz_neg;
  } carry_t;

  function automatic logic [MAG_W-1:0] mag_f(input logic signed [BEAR_W-1:0] v);
    logic signed [BEAR_W-1:0] m;
    m = v[BEAR_W-1] ? -v : v;
    return MAG_W'(m);
  endfunction

  logic signed [BEAR_W-1:0] bv    [3];
  logic [MAG_W-1:0]         mg    [3];
  logic [2*HALF_W-1:0]      hh_d  [3];
  logic [2*HALF_W-1:0]      hl_d  [3];
  logic [2*HALF_W-1:0]      ll_d  [3];
  logic [2*HALF_W-1:0]      hh_q  [3];
  logic [2*HALF_W-1:0]      hl_q  [3];
  logic [2*HALF_W-1:0]      ll_q  [3];
  logic [SQ_W-1:0]          sq_d  [3];
  logic [SQ_W-1:0]          sq_q  [3];
  logic [CMP_W-1:0]         lhs_d;
  logic [CMP_W-1:0]         rhs_d;
  logic [CMP_W-1:0]         lhs_q;
  logic [CMP_W-1:0]         rhs_q;
  logic [OFF_W-1:0]         tz_mag;
  logic signed [OFF_W:0]    tz_neg;
  carry_t                   cr_d;
  carry_t                   cr_q  [4];
  logic                     hit_q;
  logic [3:0]               vld_q;

  assign bv[0]  = bx_i;
  assign bv[1]  = by_i;
  assign bv[2]  = bz_i;
  assign tz_neg = -(OFF_W+1)'(tz_i);
  assign tz_mag = tz_i[OFF_W-1] ? OFF_W'(tz_neg) : OFF_W'(tz_i);

  // Take magnitudes and split each square into half-width partial products
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mg[a]   = mag_f(bv[a]);
      hh_d[a] = (2*HALF_W)'(mg[a][MAG_W-1:HALF_W]) * (2*HALF_W)'(mg[a][MAG_W-1:HALF_W]);
      hl_d[a] = (2*HALF_W)'(mg[a][MAG_W-1:HALF_W]) * (2*HALF_W)'(mg[a][HALF_W-1:0]);
      ll_d[a] = (2*HALF_W)'(mg[a][HALF_W-1:0]) * (2*HALF_W)'(mg[a][HALF_W-1:0]);
    end
    cr_d.num_x  = GNUM_W'(mg[0]) * GNUM_W'(tz_mag);
    cr_d.num_y  = GNUM_W'(mg[1]) * GNUM_W'(tz_mag);
    cr_d.den    = mg[2];
    cr_d.neg_x  = bx_i[BEAR_W-1] ^ tz_i[OFF_W-1];
    cr_d.neg_y  = by_i[BEAR_W-1] ^ tz_i[OFF_W-1];
    cr_d.bz_neg = bz_i[BEAR_W-1];
  end

  // Assemble the squares
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sq_d[a] = (SQ_W'(hh_q[a]) << MAG_W) + (SQ_W'(hl_q[a]) << (HALF_W + 1))
              + SQ_W'(ll_q[a]);
    end
  end

  // Compare 10000 * bz^2 against |b|^2; the constant is a sum of shifts
  always_comb begin
    rhs_d = CMP_W'(sq_q[0]) + CMP_W'(sq_q[1]) + CMP_W'(sq_q[2]);
    lhs_d = (CMP_W'(sq_q[2]) << 13) + (CMP_W'(sq_q[2]) << 10) + (CMP_W'(sq_q[2]) << 9)
          + (CMP_W'(sq_q[2]) << 8) + (CMP_W'(sq_q[2]) << 4);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < 3; a++) begin
        hh_q[a] <= hh_d[a];
        hl_q[a] <= hl_d[a];
        ll_q[a] <= ll_d[a];
        sq_q[a] <= sq_d[a];
      end
      lhs_q <= lhs_d;
      rhs_q <= rhs_d;
      hit_q <= cr_q[2].bz_neg & (lhs_q >= rhs_q);
      cr_q[0] <= cr_d;
      for (int s = 1; s < 4; s++) begin
        cr_q[s] <= cr_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  assign valid_o = vld_q[3];
  assign hit_o   = hit_q;
  assign neg_x_o = cr_q[3].neg_x;
  assign neg_y_o = cr_q[3].neg_y;
  assign num_x_o = cr_q[3].num_x;
  assign num_y_o = cr_q[3].num_y;
  assign den_o   = cr_q[3].den;

endmodule
`default_nettype wire

// ===== src/ipm_div.sv =====
`default_nettype none
module ipm_div #(
  parameter int unsigned NUM_W = 50,
  parameter int unsigned DEN_W = 34,
  parameter int unsigned QUO_W = 22,
  parameter int unsigned TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [QUO_W-1:0] quo_o,
  output logic [TAG_W-1:0] tag_o
);

  // Restoring division, one quotient bit per stage, most significant first.
  // The caller keeps num < den << QUO_W.
  localparam int unsigned EXT_W = NUM_W + QUO_W;

  logic [NUM_W-1:0] rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [TAG_W-1:0] tag_q [QUO_W];
  logic [QUO_W-1:0] vld_q;

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [TAG_W-1:0] tag_in;
    logic             vld_in;
    logic [EXT_W-1:0] trial;
    logic             fits;
    logic [NUM_W-1:0] rem_d;
    logic [QUO_W-1:0] quo_d;

    if (s == 0) begin : g_head
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign tag_in = tag_i;
      assign vld_in = valid_i;
    end else begin : g_body
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
      assign tag_in = tag_q[s-1];
      assign vld_in = vld_q[s-1];
    end

    // Subtract the shifted divisor where it fits
    assign trial = EXT_W'(den_in) << (QUO_W - 1 - s);
    assign fits  = EXT_W'(rem_in) >= trial;
    assign rem_d = fits ? NUM_W'(EXT_W'(rem_in) - trial) : rem_in;
    assign quo_d = quo_in | (QUO_W'(fits) << (QUO_W - 1 - s));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        den_q[s] <= den_in;
        quo_q[s] <= quo_d;
        tag_q[s] <= tag_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];
  assign tag_o   = tag_q[QUO_W-1];

endmodule
`default_nettype wire

// ===== src/ipm_view.sv =====
`default_nettype none
module ipm_view import ipm_pkg::*; #(
  parameter int unsigned VIEW_SIZE     = 800,
  parameter int unsigned VIEW_RANGE_MM = 30000
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic                     hit_i,
  input  logic signed [GND_W-1:0]  gx_i,
  input  logic signed [GND_W-1:0]  gy_i,
  output logic                     valid_o,
  output logic                     hit_o,
  output logic signed [GND_W-1:0]  gx_o,
  output logic signed [GND_W-1:0]  gy_o,
  output logic signed [VIEW_W-1:0] col_o,
  output logic signed [VIEW_W-1:0] row_o
);

  // Divide by 2*range through a reciprocal that already holds the view size.
  // The shift equals magnitude width plus divisor width, so the truncated
  // product equals the truncated quotient for every magnitude that fits.
  localparam int unsigned     MAGV_W = DIFF_W - 1;
  localparam int unsigned     VDEN_W = $clog2(2 * VIEW_RANGE_MM + 1);
  localparam int unsigned     VSH    = MAGV_W + VDEN_W;
  localparam longint unsigned VDEN   = 64'(2 * VIEW_RANGE_MM);
  localparam longint unsigned VMUL   = ((64'd1 << VSH) * VIEW_SIZE + VDEN - 1) / VDEN;
  localparam int unsigned     MUL_W  = $clog2(VMUL + 1);
  localparam int unsigned     LO_W   = 21;
  localparam int unsigned     HI_W   = (MUL_W > LO_W) ? MUL_W - LO_W : 1;
  localparam int unsigned     PLO_W  = MAGV_W + LO_W;
  localparam int unsigned     PHI_W  = MAGV_W + HI_W;
  localparam int unsigned     SUM_W  = PHI_W + LO_W;
  localparam int unsigned     VQ_W   = SUM_W - VSH;
  localparam logic [LO_W-1:0]          MUL_LO = LO_W'(VMUL);
  localparam logic [HI_W-1:0]          MUL_HI = HI_W'(VMUL >> LO_W);
  localparam logic signed [DIFF_W-1:0] VRNG   = DIFF_W'(VIEW_RANGE_MM);

  typedef struct packed {
    logic                    hit;
    logic signed [GND_W-1:0] gx;
    logic signed [GND_W-1:0] gy;
    logic                    neg_c;
    logic                    neg_r;
  } tag_t;

  function automatic logic signed [VIEW_W-1:0] sat_f(input logic [VQ_W-1:0] q,
                                                     input logic neg);
    logic [31:0] qe;
    logic signed [VIEW_W:0] qn;
    qe = 32'(q);
    qn = -(VIEW_W+1)'(qe[VIEW_W:0]);
    if (neg) begin
      if (qe > 32'd32768) return VIEW_W'(-32768);
      return VIEW_W'(qn);
    end
    if (qe > 32'd32767) return VIEW_W'(32767);
    return VIEW_W'(qe);
  endfunction

  logic signed [DIFF_W-1:0] dc;
  logic signed [DIFF_W-1:0] dr;
  logic signed [DIFF_W-1:0] dcn;
  logic signed [DIFF_W-1:0] drn;
  logic [MAGV_W-1:0]        mc_d;
  logic [MAGV_W-1:0]        mr_d;
  logic [MAGV_W-1:0]        mc_q;
  logic [MAGV_W-1:0]        mr_q;
  tag_t                     tag_d;
  tag_t                     tag_q;
  logic                     vld_q;
  logic [PLO_W-1:0]         plc_d;
  logic [PHI_W-1:0]         phc_d;
  logic [PLO_W-1:0]         plr_d;
  logic [PHI_W-1:0]         phr_d;
  logic [PLO_W-1:0]         plc_q;
  logic [PHI_W-1:0]         phc_q;
  logic [PLO_W-1:0]         plr_q;
  logic [PHI_W-1:0]         phr_q;
  tag_t                     tag_b_q;
  logic                     vld_b_q;
  logic [SUM_W-1:0]         sum_c;
  logic [SUM_W-1:0]         sum_r;
  logic [VQ_W-1:0]          qc;
  logic [VQ_W-1:0]          qr;
  logic signed [VIEW_W-1:0] col_d;
  logic signed [VIEW_W-1:0] row_d;
  logic signed [VIEW_W-1:0] col_q;
  logic signed [VIEW_W-1:0] row_q;
  tag_t                     out_q;
  logic                     out_vld_q;

  // Form range minus coordinate as magnitude and sign
  always_comb begin
    dc   = VRNG - DIFF_W'(gy_i);
    dr   = VRNG - DIFF_W'(gx_i);
    dcn  = -dc;
    drn  = -dr;
    mc_d = MAGV_W'(dc[DIFF_W-1] ? dcn : dc);
    mr_d = MAGV_W'(dr[DIFF_W-1] ? drn : dr);
    tag_d.hit   = hit_i;
    tag_d.gx    = gx_i;
    tag_d.gy    = gy_i;
    tag_d.neg_c = dc[DIFF_W-1];
    tag_d.neg_r = dr[DIFF_W-1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mc_q  <= mc_d;
      mr_q  <= mr_d;
      tag_q <= tag_d;
    end
  end

  // Multiply each magnitude by the low and high halves of the reciprocal
  always_comb begin
    plc_d = PLO_W'(mc_q) * PLO_W'(MUL_LO);
    phc_d = PHI_W'(mc_q) * PHI_W'(MUL_HI);
    plr_d = PLO_W'(mr_q) * PLO_W'(MUL_LO);
    phr_d = PHI_W'(mr_q) * PHI_W'(MUL_HI);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plc_q   <= plc_d;
      phc_q   <= phc_d;
      plr_q   <= plr_d;
      phr_q   <= phr_d;
      tag_b_q <= tag_q;
    end
  end

  // Join the halves, apply sign, saturate, and drop the view for a rejected pixel
  always_comb begin
    sum_c = (SUM_W'(phc_q) << LO_W) + SUM_W'(plc_q);
    sum_r = (SUM_W'(phr_q) << LO_W) + SUM_W'(plr_q);
    qc    = sum_c[SUM_W-1:VSH];
    qr    = sum_r[SUM_W-1:VSH];
    col_d = tag_b_q.hit ? sat_f(qc, tag_b_q.neg_c) : '0;
    row_d = tag_b_q.hit ? sat_f(qr, tag_b_q.neg_r) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      col_q <= col_d;
      row_q <= row_d;
      out_q <= tag_b_q;
    end
  end

  // Advance the valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= 1'b0;
      vld_b_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= valid_i;
      vld_b_q   <= vld_q;
      out_vld_q <= vld_b_q;
    end
  end

  assign valid_o = out_vld_q;
  assign hit_o   = out_q.hit;
  assign gx_o    = out_q.gx;
  assign gy_o    = out_q.gy;
  assign col_o   = col_q;
  assign row_o   = row_q;

endmodule
`default_nettype wire
